// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_SEND  = 3'd3,
		OP_RECV  = 3'd4,
		OP_WACK  = 3'd5,
		OP_FSTOP = 3'd6
	} op_t;

	localparam logic       CFG_PHASE_TICKS = 1'b0;
	localparam logic       CFG_ACK_RETRY   = 1'b1;
	localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
	localparam logic [7:0] ACK_RETRY_RST   = 8'd250;

	typedef struct packed {
		logic [7:0] phase_ticks;
		logic [7:0] ack_retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic       ack_to_send;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] phase;
		logic [3:0] bit_idx;
		logic [7:0] shift;
		logic [7:0] hold;
		logic [7:0] poll;
		logic       scl;
		logic       sda;
		logic       ack_latch;
		logic [7:0] rx_latch;
	} eng_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_fail;
		logic       rejected;
	} res_t;

	localparam eng_t ENG_RST = '{
		op: OP_IDLE, phase: 3'd0, bit_idx: 4'd0, shift: 8'd0, hold: 8'd0,
		poll: 8'd0, scl: 1'b1, sda: 1'b1, ack_latch: 1'b0, rx_latch: 8'd0
	};

endpackage

// ===== rtl/i2cm_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cm_cfg
// Configuration registers; a zero phase length is stored as one.
// ----------------------------------------------------------------------------
module i2cm_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [7:0]    cfg_wdata,
	output i2cm_pkg::cfg_t cfg
);
	import i2cm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks     <= PHASE_TICKS_RST;
			cfg_q.ack_retry_limit <= ACK_RETRY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PHASE_TICKS: begin
					cfg_q.phase_ticks <= (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
				end
				CFG_ACK_RETRY: begin
					cfg_q.ack_retry_limit <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the bit sequencer: next engine state and the result item.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::cfg_t  cfg,
	input  i2cm_pkg::item_t item,
	input  i2cm_pkg::eng_t  cur,
	output i2cm_pkg::eng_t  nxt,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	logic run;
	logic done;
	logic fail;
	logic rej;

	always_comb begin
		nxt  = cur;
		run  = 1'b0;
		done = 1'b0;
		fail = 1'b0;
		rej  = 1'b0;
		if (cur.op != OP_IDLE) begin
			rej = (item.cmd != 3'(OP_IDLE));
			if (cur.hold > 8'd1) begin
				nxt.hold = cur.hold - 8'd1;
			end else begin
				nxt.hold = 8'd0;
				run      = 1'b1;
			end
		end else if ((item.cmd >= 3'(OP_START)) && (item.cmd <= 3'(OP_WACK))) begin
			nxt.op        = op_t'(item.cmd);
			nxt.phase     = 3'd0;
			nxt.bit_idx   = 4'd0;
			nxt.poll      = 8'd0;
			nxt.hold      = 8'd0;
			nxt.shift     = (item.cmd == 3'(OP_SEND)) ? item.data_byte : 8'd0;
			nxt.ack_latch = item.ack_to_send;
			run           = 1'b1;
		end

		if (run) begin
			unique case (nxt.op)
				OP_START: begin
					if (nxt.phase == 3'd0) begin
						nxt.sda = 1'b1; nxt.scl = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd1;
					end else if (nxt.phase == 3'd1) begin
						nxt.sda = 1'b0;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd2;
					end else begin
						nxt.scl = 1'b0;
						done = 1'b1;
					end
				end
				OP_STOP, OP_FSTOP: begin
					if (nxt.phase == 3'd0) begin
						nxt.sda = 1'b0;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd1;
					end else if (nxt.phase == 3'd1) begin
						nxt.scl = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd2;
					end else begin
						nxt.sda = 1'b1;
						done = 1'b1;
						fail = (nxt.op == OP_FSTOP);
					end
				end
				OP_SEND: begin
					if (nxt.phase == 3'd0) begin
						nxt.sda   = nxt.shift[7];
						nxt.shift = {nxt.shift[6:0], 1'b0};
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd1;
					end else if (nxt.phase == 3'd1) begin
						nxt.scl = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd2;
					end else if (nxt.phase == 3'd2) begin
						nxt.scl     = 1'b0;
						nxt.bit_idx = nxt.bit_idx + 4'd1;
						nxt.hold    = cfg.phase_ticks;
						nxt.phase   = (nxt.bit_idx < 4'd8) ? 3'd0 : 3'd3;
					end else begin
						nxt.sda = 1'b1;
						done = 1'b1;
					end
				end
				OP_RECV: begin
					if (nxt.phase == 3'd0) begin
						nxt.sda = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd1;
					end else if (nxt.phase == 3'd1) begin
						nxt.shift = {nxt.shift[6:0], 1'b0};
						nxt.scl   = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd2;
					end else if (nxt.phase == 3'd2) begin
						nxt.shift   = {nxt.shift[7:1], item.sda_in};
						nxt.scl     = 1'b0;
						nxt.bit_idx = nxt.bit_idx + 4'd1;
						nxt.hold    = cfg.phase_ticks;
						nxt.phase   = (nxt.bit_idx < 4'd8) ? 3'd1 : 3'd3;
					end else if (nxt.phase == 3'd3) begin
						nxt.sda = ~nxt.ack_latch;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd4;
					end else if (nxt.phase == 3'd4) begin
						nxt.scl = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd5;
					end else begin
						nxt.scl = 1'b0;
						if (nxt.ack_latch) begin
							nxt.sda = 1'b1;
						end
						nxt.rx_latch = nxt.shift;
						done = 1'b1;
					end
				end
				OP_WACK: begin
					if (nxt.phase == 3'd0) begin
						nxt.sda = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd1;
					end else if (nxt.phase == 3'd1) begin
						nxt.scl = 1'b1;
						nxt.hold = cfg.phase_ticks; nxt.phase = 3'd2;
					end else if (nxt.phase == 3'd2) begin
						if (!item.sda_in) begin
							nxt.scl = 1'b0;
							nxt.hold = cfg.phase_ticks; nxt.phase = 3'd3;
						end else if (nxt.poll >= cfg.ack_retry_limit) begin
							nxt.op  = OP_FSTOP;
							nxt.sda = 1'b0;
							nxt.hold = cfg.phase_ticks; nxt.phase = 3'd1;
						end else begin
							nxt.poll = nxt.poll + 8'd1;
							nxt.hold = 8'd0;
						end
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (done) begin
				nxt.op    = OP_IDLE;
				nxt.phase = 3'd0;
				nxt.hold  = 8'd0;
			end
		end
	end

	always_comb begin
		res.scl_out  = nxt.scl;
		res.sda_out  = nxt.sda;
		res.busy_res = (nxt.op != OP_IDLE);
		res.done_res = done;
		res.rx_byte  = nxt.rx_latch;
		res.ack_fail = fail;
		res.rejected = rej;
	end

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: one tick per transaction, one result per tick.
//
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: cmd; tdata: data_byte, ack_to_send, sda_in
// m_axis    out        tdata: scl_out, sda_out, busy_res, done_res, rx_byte,
//                      ack_fail, rejected
// cfg       in         index 0 phase_ticks, index 1 ack_retry_limit
//
// A tick is registered on input, stepped through the sequencer and written to
// the output register with the engine state. One tick is taken every cycle
// while m_axis is not stalled; the engine state loop through the step logic
// sets that rate.
// Reset leaves the engine idle with SCL and SDA released.
// A stall on m_axis holds the input stage, which then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte, ack_to_send, sda_in
	input  logic [2:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // scl_out, sda_out, busy_res, done_res,
	                                   // rx_byte, ack_fail, rejected
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_wdata
);
	import i2cm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  vld_s1;
	eng_t  eng_q;
	eng_t  eng_nxt;
	res_t  res_nxt;
	res_t  res_q;
	logic  out_vld_q;
	logic  advance;

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cm_step u_step (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (eng_q),
		.nxt  (eng_nxt),
		.res  (res_nxt)
	);

	assign advance       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd         <= s_axis_tuser;
			item_s1.data_byte   <= s_axis_tdata[7:0];
			item_s1.ack_to_send <= s_axis_tdata[8];
			item_s1.sda_in      <= s_axis_tdata[9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q     <= ENG_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				eng_q <= eng_nxt;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, res_q.rejected, res_q.ack_fail, res_q.rx_byte,
		res_q.done_res, res_q.busy_res, res_q.sda_out, res_q.scl_out};

endmodule

// ===== rtl/i2cm_chk.sv =====
// ----------------------------------------------------------------------------
// i2cm_chk
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A finishing tick always leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
		else $error("done reported while still busy");

	// A failed acknowledge wait is only reported with its done pulse.
	a_fail_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[3])
		else $error("ack_fail without done");

	// The stop sequence after a failed wait ends with both lines released.
	a_fail_bus: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[0] && m_axis_tdata[1])
		else $error("ack_fail with a line still driven low");

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind i2c_master_bit_engine i2cm_chk u_chk (.*);

// ===== dv/i2c_bit_engine_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_engine_checker
// Watches the tick and pin-level streams of the I2C master bit engine, keeps
// its own model of the bus sequencer and compares every result field by field.
// ----------------------------------------------------------------------------
module i2c_bit_engine_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte, ack_to_send, sda_in
	input  logic [2:0]  s_axis_tuser,  // cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // scl_out, sda_out, busy_res, done_res,
	                                   // rx_byte, ack_fail, rejected
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_wdata,
	output int          errors,
	output int          pending
);
	import i2cm_pkg::*;

	localparam int REPORT_MAX = 50;

	op_t        op;
	logic [2:0] step;
	logic [3:0] bit_cnt;
	logic [7:0] shreg;
	logic [7:0] hold_cnt;
	logic [7:0] poll_cnt;
	logic [7:0] rx_hold;
	logic       scl_lvl;
	logic       sda_lvl;
	logic       ack_hold;
	logic       done_pulse;
	logic       fail_pulse;
	logic [7:0] tick_len;
	logic [7:0] retry_max;

	res_t expected_pins[$];
	res_t want;
	res_t got;

	function automatic void set_hold(input logic [2:0] nxt);
		hold_cnt = tick_len;
		step = nxt;
	endfunction

	function automatic void finish_cmd(input logic failed);
		op = OP_IDLE;
		step = 3'd0;
		hold_cnt = 8'd0;
		done_pulse = 1'b1;
		fail_pulse = failed;
	endfunction

	function automatic void advance(input logic sda);
		case (op)
			OP_START: begin
				if (step == 3'd0) begin
					sda_lvl = 1'b1;
					scl_lvl = 1'b1;
					set_hold(3'd1);
				end else if (step == 3'd1) begin
					sda_lvl = 1'b0;
					set_hold(3'd2);
				end else begin
					scl_lvl = 1'b0;
					finish_cmd(1'b0);
				end
			end
			OP_STOP, OP_FSTOP: begin
				if (step == 3'd0) begin
					sda_lvl = 1'b0;
					set_hold(3'd1);
				end else if (step == 3'd1) begin
					scl_lvl = 1'b1;
					set_hold(3'd2);
				end else begin
					sda_lvl = 1'b1;
					finish_cmd(op == OP_FSTOP);
				end
			end
			OP_SEND: begin
				if (step == 3'd0) begin
					sda_lvl = shreg[7];
					shreg = shreg << 1;
					set_hold(3'd1);
				end else if (step == 3'd1) begin
					scl_lvl = 1'b1;
					set_hold(3'd2);
				end else if (step == 3'd2) begin
					scl_lvl = 1'b0;
					bit_cnt++;
					set_hold((bit_cnt < 4'd8) ? 3'd0 : 3'd3);
				end else begin
					sda_lvl = 1'b1;
					finish_cmd(1'b0);
				end
			end
			OP_RECV: begin
				if (step == 3'd0) begin
					sda_lvl = 1'b1;
					set_hold(3'd1);
				end else if (step == 3'd1) begin
					shreg = shreg << 1;
					scl_lvl = 1'b1;
					set_hold(3'd2);
				end else if (step == 3'd2) begin
					shreg[0] = sda;
					scl_lvl = 1'b0;
					bit_cnt++;
					set_hold((bit_cnt < 4'd8) ? 3'd1 : 3'd3);
				end else if (step == 3'd3) begin
					sda_lvl = !ack_hold;
					set_hold(3'd4);
				end else if (step == 3'd4) begin
					scl_lvl = 1'b1;
					set_hold(3'd5);
				end else begin
					scl_lvl = 1'b0;
					if (ack_hold)
						sda_lvl = 1'b1;
					rx_hold = shreg;
					finish_cmd(1'b0);
				end
			end
			OP_WACK: begin
				if (step == 3'd0) begin
					sda_lvl = 1'b1;
					set_hold(3'd1);
				end else if (step == 3'd1) begin
					scl_lvl = 1'b1;
					set_hold(3'd2);
				end else if (step == 3'd2) begin
					if (!sda) begin
						scl_lvl = 1'b0;
						set_hold(3'd3);
					end else if (poll_cnt >= retry_max) begin
						// The slave never pulled SDA low, so release the bus with a stop.
						op = OP_FSTOP;
						sda_lvl = 1'b0;
						set_hold(3'd1);
					end else begin
						poll_cnt++;
						hold_cnt = 8'd0;
					end
				end else begin
					finish_cmd(1'b0);
				end
			end
			default: finish_cmd(1'b0);
		endcase
	endfunction

	function automatic res_t step_engine(input logic [2:0] cmd, input logic [7:0] data,
			input logic ack, input logic sda);
		res_t r;
		logic rej;
		rej = 1'b0;
		done_pulse = 1'b0;
		fail_pulse = 1'b0;
		if (op != OP_IDLE) begin
			if (cmd != OP_IDLE)
				rej = 1'b1;
			if (hold_cnt > 8'd1) begin
				hold_cnt--;
			end else begin
				hold_cnt = 8'd0;
				advance(sda);
			end
		end else if (cmd >= OP_START && cmd <= OP_WACK) begin
			op = op_t'(cmd);
			step = 3'd0;
			bit_cnt = 4'd0;
			poll_cnt = 8'd0;
			hold_cnt = 8'd0;
			shreg = (cmd == OP_SEND) ? data : 8'd0;
			ack_hold = ack;
			advance(sda);
		end
		r.scl_out = scl_lvl;
		r.sda_out = sda_lvl;
		r.busy_res = (op != OP_IDLE);
		r.done_res = done_pulse;
		r.rx_byte = rx_hold;
		r.ack_fail = fail_pulse;
		r.rejected = rej;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			if (errors < REPORT_MAX)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op = OP_IDLE;
			step = 3'd0;
			bit_cnt = 4'd0;
			shreg = 8'd0;
			hold_cnt = 8'd0;
			poll_cnt = 8'd0;
			rx_hold = 8'd0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			ack_hold = 1'b0;
			done_pulse = 1'b0;
			fail_pulse = 1'b0;
			tick_len = PHASE_TICKS_RST;
			retry_max = ACK_RETRY_RST;
			expected_pins.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_PHASE_TICKS)
					tick_len = (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
				else
					retry_max = cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.scl_out  = m_axis_tdata[0];
				got.sda_out  = m_axis_tdata[1];
				got.busy_res = m_axis_tdata[2];
				got.done_res = m_axis_tdata[3];
				got.rx_byte  = m_axis_tdata[11:4];
				got.ack_fail = m_axis_tdata[12];
				got.rejected = m_axis_tdata[13];
				if (expected_pins.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("%0t: result with no transaction waiting, expected none, got %0h",
							$time, got);
					errors++;
				end else begin
					want = expected_pins.pop_front();
					check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
					check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
					check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(got.done_res));
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("ack_fail", 8'(want.ack_fail), 8'(got.ack_fail));
					check_field("rejected", 8'(want.rejected), 8'(got.rejected));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_pins.push_back(step_engine(s_axis_tuser, s_axis_tdata[7:0],
					s_axis_tdata[8], s_axis_tdata[9]));
			pending <= expected_pins.size();
		end
	end

endmodule

// ===== dv/i2c_master_bit_engine_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Drives tick transactions into the I2C master bit engine: a short directed
// opening, then well-formed command sequences with random content and noise
// under several timing settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
	import i2cm_pkg::*;

	localparam logic [2:0] CMD_UNUSED     = 3'd7;
	localparam int         WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // data_byte, ack_to_send, sda_in
	logic [2:0]  s_axis_tuser = '0;  // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // scl_out, sda_out, busy_res, done_res,
	                                 // rx_byte, ack_fail, rejected
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	int   errors;
	int   pending;
	int   sent = 0;
	int   cur_phase = PHASE_TICKS_RST;
	int   cur_limit = ACK_RETRY_RST;
	bit   sender_calm = 1'b0;
	bit   rx_calm = 1'b0;
	int   stall_left = 0;
	int   idle_cycles = 0;

	i2c_master_bit_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata)
	);

	i2c_bit_engine_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_calm && $urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(10, 60);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_tick(input logic [2:0] cmd, input logic [7:0] data, input logic ack,
			input logic sda);
		int r;
		int gap;
		gap = 0;
		if (!sender_calm) begin
			r = $urandom_range(0, 99);
			if (r >= 97)
				gap = $urandom_range(10, 40);
			else if (r >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'd0, sda, ack, data};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic configure(input int p, input int lim);
		drain();
		write_reg(CFG_PHASE_TICKS, p[7:0]);
		write_reg(CFG_ACK_RETRY, lim[7:0]);
		cfg_we <= 1'b0;
		cur_phase = (p == 0) ? 1 : p;
		cur_limit = lim;
	endtask

	function automatic int cmd_ticks(input logic [2:0] cmd, input int polls);
		case (cmd)
			OP_START, OP_STOP: return 2 * cur_phase + 1;
			OP_SEND:           return 24 * cur_phase + 1;
			OP_RECV:           return 19 * cur_phase + 1;
			OP_WACK: begin
				if (polls > cur_limit)
					return 4 * cur_phase + cur_limit + 1;
				return 3 * cur_phase + polls + 1;
			end
			default:           return 1;
		endcase
	endfunction

	// Issues one command and enough plain ticks to carry it to its end. Now and
	// then the next command is sent one tick early, on the finishing tick, where it is rejected.
	task automatic run_command(input logic [2:0] cmd, input int polls);
		int len;
		int t;
		int r;
		logic sda;
		logic [2:0] c;
		len = cmd_ticks(cmd, polls);
		r = $urandom_range(0, 9);
		if (r == 0)
			len = len - 1;
		else if (r < 3)
			len = len + $urandom_range(1, 3);
		for (t = 0; t < len; t++) begin
			sda = 1'($urandom_range(0, 1));
			if (cmd == OP_WACK && t >= 2 * cur_phase)
				sda = (t < 2 * cur_phase + polls);
			c = (t == 0) ? cmd : OP_IDLE;
			if (t > 0 && $urandom_range(0, 31) == 0)
				c = 3'($urandom_range(OP_START, CMD_UNUSED));
			send_tick(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
		end
	endtask

	task automatic run_phase(input int p, input int lim, input int budget);
		int first;
		int polls;
		logic [2:0] cmd;
		configure(p, lim);
		sender_calm = 1'b0;
		rx_calm = 1'b0;
		first = sent;
		while (sent - first < budget) begin
			if ($urandom_range(0, 7) == 0) begin
				sender_calm = ($urandom_range(0, 2) == 0);
				rx_calm = ($urandom_range(0, 2) == 0);
			end
			case ($urandom_range(0, 5))
				0: cmd = OP_START;
				1: cmd = OP_STOP;
				2: cmd = OP_SEND;
				3: cmd = OP_RECV;
				4: cmd = OP_WACK;
				default: begin
					case ($urandom_range(0, 2))
						0: cmd = OP_IDLE;
						1: cmd = OP_FSTOP;
						default: cmd = CMD_UNUSED;
					endcase
				end
			endcase
			if (cur_limit <= 8)
				polls = $urandom_range(0, cur_limit + 1);
			else if ($urandom_range(0, 5) == 0)
				polls = cur_limit + 1;
			else
				polls = $urandom_range(0, 6);
			if (cmd_ticks(cmd, polls) > budget - (sent - first))
				cmd = OP_IDLE;
			run_command(cmd, polls);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(OP_IDLE, 8'hFF, 1'b1, 1'b1);
		send_tick(OP_FSTOP, 8'h00, 1'b0, 1'b0);
		send_tick(CMD_UNUSED, 8'hA5, 1'b1, 1'b0);
		send_tick(OP_START, 8'h00, 1'b0, 1'b1);
		send_tick(OP_IDLE, 8'h5A, 1'b0, 1'b0);
		send_tick(OP_WACK, 8'h00, 1'b1, 1'b1);
		send_tick(OP_IDLE, 8'h00, 1'b0, 1'b0);
		send_tick(OP_SEND, 8'hFF, 1'b1, 1'b1);
		send_tick(OP_STOP, 8'h00, 1'b0, 1'b0);
		repeat (4) send_tick(OP_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'b1);

		configure(0, 0);
		send_tick(OP_WACK, 8'h00, 1'b0, 1'b1);
		repeat (4) send_tick(OP_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'b1);
		send_tick(OP_WACK, 8'hFF, 1'b1, 1'b1);
		send_tick(OP_IDLE, 8'h00, 1'b0, 1'b1);
		send_tick(OP_IDLE, 8'h00, 1'b0, 1'b0);
		send_tick(OP_IDLE, 8'h00, 1'b0, 1'b0);

		run_phase(2, 250, 280);
		run_phase(1, 3, 280);
		run_phase(3, 0, 150);
		run_phase(255, 255, 520);
		configure(1, 255);
		run_command(OP_WACK, 256);
		run_phase(2, 8, 150);

		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== i2c_master_bit_engine.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_cfg.sv
rtl/i2cm_step.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_chk.sv
dv/i2c_bit_engine_checker.sv
dv/i2c_master_bit_engine_tb.sv
